@@ design/rwcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwcp_pkg
// Shared types, chunk tags and signature table for the RIFF/WAVE parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

    // file geometry
    localparam logic [31:0] MIN_FILE_LEN = 32'd44;
    localparam logic [31:0] WALK_START   = 32'd12;
    localparam logic [31:0] FMT_CAPTURE  = 32'd16;

    // chunk tags, little-endian as they arrive
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'd1;

    // walk stages
    localparam logic [1:0] STG_HEADER  = 2'd0;
    localparam logic [1:0] STG_BODY    = 2'd1;
    localparam logic [1:0] STG_STOPPED = 2'd2;

    // report status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_SIG   = 2'd2;
    localparam logic [1:0] ST_MISSING   = 2'd3;

    // result kinds
    localparam logic KIND_AUDIO  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [7:0]  file_byte;
        logic [31:0] file_length;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  audio_byte;
        logic [1:0]  status;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] bytes_per_sec;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic step;         // input item accepted this cycle
        logic load_audio;   // put the current byte into the output register
        logic mul1;         // channels * bits
        logic mul2;         // align fix and byte rate
        logic load_report;  // put the report out and clear all walk state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;   // current input byte is audio
        logic last;   // current input byte ends the file
    } t_sts;

    // 1 when a byte of the 12-byte file signature does not match
    function automatic logic sig_mismatch(input logic [3:0] pos, input logic [7:0] b);
        logic [7:0] want;
        logic       care;
        care = 1'b1;
        want = 8'h00;
        case (pos)
            4'd0:    want = 8'h52;  // R
            4'd1:    want = 8'h49;  // I
            4'd2:    want = 8'h46;  // F
            4'd3:    want = 8'h46;  // F
            4'd8:    want = 8'h57;  // W
            4'd9:    want = 8'h41;  // A
            4'd10:   want = 8'h56;  // V
            4'd11:   want = 8'h45;  // E
            default: care = 1'b0;   // size field, unchecked
        endcase
        return care && (want != b);
    endfunction

endpackage

@@ design/rwcp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwcp_ctrl
// Sequencer: byte intake, report arithmetic steps and output register valid.
// ----------------------------------------------------------------------------
module rwcp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  rwcp_pkg::t_sts i_sts,
    output rwcp_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL1   = 2'd1;
    localparam logic [1:0] S_MUL2   = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       accept;

    // output register can take a new item this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.step        = accept;
        o_cmd.load_audio  = accept && i_sts.emit;
        o_cmd.mul1        = (r_state == S_MUL1);
        o_cmd.mul2        = (r_state == S_MUL2);
        o_cmd.load_report = (r_state == S_REPORT) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && i_sts.last) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_REPORT;
            S_REPORT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_audio || o_cmd.load_report) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/rwcp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwcp_dp
// Chunk walker, format capture, report arithmetic and output register.
// ----------------------------------------------------------------------------
module rwcp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rwcp_pkg::t_in_item  i_in_data,
    input  rwcp_pkg::t_cmd      i_cmd,
    output rwcp_pkg::t_sts      o_sts,
    output rwcp_pkg::t_out_item o_out_data
);

    logic [31:0] r_pos,       n_pos;
    logic [1:0]  r_stage,     n_stage;
    logic [2:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [31:0] r_tag,       n_tag;
    logic [31:0] r_size,      n_size;
    logic [32:0] r_remain,    n_remain;
    logic [32:0] r_off,       n_off;
    logic        r_sig_ok,    n_sig_ok;
    logic        r_have_fmt,  n_have_fmt;
    logic        r_have_data, n_have_data;
    logic [31:0] r_last_size, n_last_size;
    logic [7:0]  r_fmt [16];
    logic [1:0]  r_status;
    logic [15:0] r_expect;
    logic [15:0] r_align;
    logic [31:0] r_bps;
    rwcp_pkg::t_out_item r_out, n_out;

    logic [7:0]  b;
    logic [31:0] flen;
    logic        walk_en;
    logic        in_body;
    logic        body_fmt;
    logic        emit;
    logic        store_wr;
    logic        store_clr;
    logic [31:0] size_full;
    logic [33:0] chunk_end;
    logic        overrun;
    logic [1:0]  status_now;

    logic [15:0] f_tag, f_ch, f_align, f_bits;
    logic [31:0] f_rate, f_bps;
    logic [31:0] ch_bits;
    logic [15:0] align_fix;
    logic [47:0] rate_align;

    assign b    = i_in_data.file_byte;
    assign flen = i_in_data.file_length;

    // walk gating and body byte decode
    assign walk_en = (r_pos >= rwcp_pkg::WALK_START) && (flen >= rwcp_pkg::MIN_FILE_LEN)
                     && r_sig_ok && (r_pos < flen) && (r_stage != rwcp_pkg::STG_STOPPED);
    assign in_body  = walk_en && (r_stage == rwcp_pkg::STG_BODY);
    assign body_fmt = (r_tag == rwcp_pkg::TAG_FMT) && (r_size >= rwcp_pkg::FMT_CAPTURE);
    assign emit     = in_body && (r_tag == rwcp_pkg::TAG_DATA) && (r_off < {1'b0, r_size});
    assign store_wr = i_cmd.step && in_body && body_fmt && (r_off[32:4] == '0);

    assign o_sts.emit = emit;
    assign o_sts.last = i_in_data.last_byte;

    // header completion: size with its top byte arriving now
    assign size_full = {b, r_size[23:0]};
    assign chunk_end = {2'b00, r_pos} + 34'd1 + {2'b00, size_full};
    assign overrun   = chunk_end > {2'b00, flen};

    // per-byte state update
    always_comb begin
        n_pos       = (r_pos == '1) ? r_pos : r_pos + 32'd1;
        n_stage     = r_stage;
        n_hdr_cnt   = r_hdr_cnt;
        n_tag       = r_tag;
        n_size      = r_size;
        n_remain    = r_remain;
        n_off       = r_off;
        n_sig_ok    = r_sig_ok;
        n_have_fmt  = r_have_fmt;
        n_have_data = r_have_data;
        n_last_size = r_last_size;
        store_clr   = 1'b0;

        if (r_pos < rwcp_pkg::WALK_START) begin
            if (rwcp_pkg::sig_mismatch(r_pos[3:0], b)) n_sig_ok = 1'b0;
        end else if (walk_en && r_stage == rwcp_pkg::STG_BODY) begin
            n_off    = r_off + 33'd1;
            n_remain = r_remain - 33'd1;
            if (r_remain == 33'd1) n_stage = rwcp_pkg::STG_HEADER;
        end else if (walk_en) begin
            // header byte: tag bytes 0..3, size bytes 4..7
            n_hdr_cnt = r_hdr_cnt + 3'd1;
            if (r_hdr_cnt == 3'd0) begin
                n_tag  = {24'd0, b};
                n_size = '0;
            end else if (!r_hdr_cnt[2]) begin
                n_tag[8*r_hdr_cnt[1:0] +: 8] = b;
            end else begin
                n_size[8*r_hdr_cnt[1:0] +: 8] = b;
            end
            if (r_hdr_cnt == 3'd7) begin
                n_hdr_cnt = '0;
                n_off     = '0;
                if (overrun) begin
                    n_stage  = rwcp_pkg::STG_STOPPED;
                    n_remain = '0;
                end else begin
                    if (r_tag == rwcp_pkg::TAG_FMT && size_full >= rwcp_pkg::FMT_CAPTURE) begin
                        store_clr  = 1'b1;
                        n_have_fmt = 1'b1;
                    end else if (r_tag == rwcp_pkg::TAG_DATA) begin
                        n_have_data = 1'b1;
                        n_last_size = size_full;
                    end
                    // odd bodies carry a pad byte
                    n_remain = {1'b0, size_full} + {32'd0, size_full[0]};
                    n_stage  = (size_full == '0) ? rwcp_pkg::STG_HEADER : rwcp_pkg::STG_BODY;
                end
            end
        end
    end

    // report status as it stands after the final byte
    always_comb begin
        if (flen < rwcp_pkg::MIN_FILE_LEN) begin
            status_now = rwcp_pkg::ST_SHORT;
        end else if (!n_sig_ok || r_pos < (rwcp_pkg::WALK_START - 32'd1)) begin
            status_now = rwcp_pkg::ST_BAD_SIG;
        end else if (!n_have_fmt || !n_have_data) begin
            status_now = rwcp_pkg::ST_MISSING;
        end else begin
            status_now = rwcp_pkg::ST_OK;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_report) begin
            r_pos       <= '0;
            r_stage     <= rwcp_pkg::STG_HEADER;
            r_hdr_cnt   <= '0;
            r_tag       <= '0;
            r_size      <= '0;
            r_remain    <= '0;
            r_off       <= '0;
            r_sig_ok    <= 1'b1;
            r_have_fmt  <= 1'b0;
            r_have_data <= 1'b0;
            r_last_size <= '0;
        end else if (i_cmd.step) begin
            r_pos       <= n_pos;
            r_stage     <= n_stage;
            r_hdr_cnt   <= n_hdr_cnt;
            r_tag       <= n_tag;
            r_size      <= n_size;
            r_remain    <= n_remain;
            r_off       <= n_off;
            r_sig_ok    <= n_sig_ok;
            r_have_fmt  <= n_have_fmt;
            r_have_data <= n_have_data;
            r_last_size <= n_last_size;
        end
    end

    // format store: first 16 body bytes of the latest fmt chunk of 16 bytes or more
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_report || (i_cmd.step && store_clr)) begin
            for (int i = 0; i < 16; i++) r_fmt[i] <= '0;
        end else if (store_wr) begin
            r_fmt[r_off[3:0]] <= b;
        end
    end

    // format fields
    assign f_tag   = {r_fmt[1],  r_fmt[0]};
    assign f_ch    = {r_fmt[3],  r_fmt[2]};
    assign f_rate  = {r_fmt[7],  r_fmt[6],  r_fmt[5], r_fmt[4]};
    assign f_bps   = {r_fmt[11], r_fmt[10], r_fmt[9], r_fmt[8]};
    assign f_align = {r_fmt[13], r_fmt[12]};
    assign f_bits  = {r_fmt[15], r_fmt[14]};

    // PCM fix-up arithmetic
    assign ch_bits    = f_ch * f_bits;
    assign align_fix  = (f_tag == rwcp_pkg::FMT_PCM && r_expect != '0 && f_align != r_expect)
                        ? r_expect : f_align;
    assign rate_align = f_rate * align_fix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && i_in_data.last_byte) r_status <= status_now;
        if (i_cmd.mul1) r_expect <= ch_bits[18:3];
        if (i_cmd.mul2) begin
            r_align <= align_fix;
            r_bps   <= (f_tag == rwcp_pkg::FMT_PCM) ? rate_align[31:0] : f_bps;
        end
    end

    // output register next value
    always_comb begin
        n_out = r_out;
        if (i_cmd.load_audio) begin
            n_out            = '0;
            n_out.kind       = rwcp_pkg::KIND_AUDIO;
            n_out.audio_byte = b;
        end else if (i_cmd.load_report) begin
            n_out        = '0;
            n_out.kind   = rwcp_pkg::KIND_REPORT;
            n_out.status = r_status;
            if (r_status == rwcp_pkg::ST_OK) begin
                n_out.format_tag      = f_tag;
                n_out.channels        = f_ch;
                n_out.sample_rate     = f_rate;
                n_out.bytes_per_sec   = r_bps;
                n_out.block_align     = r_align;
                n_out.bits_per_sample = f_bits;
                n_out.data_length     = r_last_size;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

@@ design/riff_wave_chunk_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser_top
// RIFF/WAVE byte-stream parser: forwards data chunk audio, reports format.
// ----------------------------------------------------------------------------
// Feed the file one byte per item with its total length and a last-byte mark.
// A file streams at one byte per clock as long as the output side keeps taking
// items; the single output register is the only buffering, so while an output
// item waits under stall no input item is taken. After the last byte the parser
// takes no new file until it has done the report arithmetic (channels*bits, then
// the block align fix and rate*block align) and loaded the report once the
// output register is free. Audio bytes of every complete data chunk come
// out first, then one report item ends the file, and the parser returns to
// its reset state for the next file.
module riff_wave_chunk_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rwcp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rwcp_pkg::t_out_item o_out_data
);

    rwcp_pkg::t_cmd cmd;
    rwcp_pkg::t_sts sts;

    rwcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rwcp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
